@@ hdl/flood_collect_slot_engine_unit_defines.svh @@
// Assertion macros shared by the flood collect slot engine.
`ifndef FLOOD_COLLECT_SLOT_ENGINE_UNIT_DEFINES_SVH
`define FLOOD_COLLECT_SLOT_ENGINE_UNIT_DEFINES_SVH

// Check that an implication holds at every clock edge outside reset.
`define FCSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication holds in the cycle after its trigger.
`define FCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fcse_pkg.sv @@
// ----------------------------------------------------------------------------
// fcse_pkg
// Shared types and constants of the flood collect slot engine.
// ----------------------------------------------------------------------------
`default_nettype none
package fcse_pkg;
    localparam int MAX_NODES  = 64;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS   = $clog2(MAX_NODES + 1);

    localparam logic [3:0] RESTART_MIN = 4'd6;

    localparam logic [2:0] REG_NODE_COUNT = 3'd0;
    localparam logic [2:0] REG_OWN_INDEX  = 3'd1;
    localparam logic [2:0] REG_INITIATOR  = 3'd2;
    localparam logic [2:0] REG_MAX_SLOTS  = 3'd3;
    localparam logic [2:0] REG_TX_TARGET  = 3'd4;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_RX   = 2'd1;
    localparam logic [1:0] ST_TX   = 2'd2;

    localparam logic [1:0] NX_RX  = 2'd0;
    localparam logic [1:0] NX_TX  = 2'd1;
    localparam logic [1:0] NX_OFF = 2'd2;

    localparam logic CMD_START = 1'b0;

    typedef struct packed {
        logic                  command;
        logic [VALUE_BITS-1:0] own_value;
        logic [1:0]            slot_state;
        logic                  txrx_ok;
        logic [15:0]           slot_number;
        logic [15:0]           random_word;
        logic                  rx_flag;
        logic [VALUE_BITS-1:0] rx_value;
        logic                  last_entry;
    } item_t;

    typedef struct packed {
        logic                  stored_flag;
        logic [VALUE_BITS-1:0] stored_value;
        logic                  decision_valid;
        logic [1:0]            slot_action;
        logic                  is_complete;
        logic [15:0]           complete_at;
        logic                  round_end;
        logic [15:0]           closing_slot;
    } result_t;

    // classified item handed from front to back
    typedef struct packed {
        item_t               item;
        logic [IDX_BITS-1:0] idx;
        logic                in_range;
        logic                own_valid;
    } op_t;

    typedef struct packed {
        logic [6:0]  node_count;
        logic [5:0]  own_index;
        logic        initiator;
        logic [15:0] max_slots;
        logic [7:0]  tx_complete_target;
    } cfg_t;
endpackage
`default_nettype wire

@@ hdl/fcse_front.sv @@
// ----------------------------------------------------------------------------
// fcse_front
// Accepts items, tracks the entry position and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none
module fcse_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire fcse_pkg::item_t item,
    input  wire fcse_pkg::cfg_t  cfg,
    output fcse_pkg::op_t        op
);
    logic [fcse_pkg::IDX_BITS-1:0] entry_reg;
    logic [fcse_pkg::IDX_BITS-1:0] entry_next;
    logic [fcse_pkg::CNT_BITS-1:0] nc;

    // clamp node count into 1..MAX_NODES
    always_comb
    begin
        if (cfg.node_count == 7'd0)
            nc = fcse_pkg::CNT_BITS'(1);
        else if (32'(cfg.node_count) > fcse_pkg::MAX_NODES)
            nc = fcse_pkg::CNT_BITS'(fcse_pkg::MAX_NODES);
        else
            nc = fcse_pkg::CNT_BITS'(cfg.node_count);
    end

    // classify: pick the entry index and range, and the next entry position
    always_comb
    begin
        op.item      = item;
        op.own_valid = 32'(cfg.own_index) < fcse_pkg::MAX_NODES;
        if (item.command == fcse_pkg::CMD_START)
        begin
            op.idx      = op.own_valid ? fcse_pkg::IDX_BITS'(cfg.own_index) : '0;
            op.in_range = op.own_valid && (32'(cfg.own_index) < 32'(nc));
        end
        else
        begin
            op.idx      = entry_reg;
            op.in_range = 32'(entry_reg) < 32'(nc);
        end
        entry_next = entry_reg;
        if (item.command == fcse_pkg::CMD_START || item.last_entry)
            entry_next = '0;
        else if (32'(entry_reg) + 1 >= fcse_pkg::MAX_NODES)
            entry_next = '0;
        else
            entry_next = entry_reg + 1'b1;
    end

    // advance entry counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else if (take)
            entry_reg <= entry_next;
    end
endmodule
`default_nettype wire

@@ hdl/fcse_queue.sv @@
// ----------------------------------------------------------------------------
// fcse_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module fcse_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire fcse_pkg::op_t wdata,
    output logic               full,
    input  wire logic          rd,
    output fcse_pkg::op_t      rdata,
    output logic               empty
);
    fcse_pkg::op_t mem_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    // store payload
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

@@ hdl/fcse_back.sv @@
// ----------------------------------------------------------------------------
// fcse_back
// Merges entries into the store and decides the next slot action.
// ----------------------------------------------------------------------------
`default_nettype none
module fcse_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            go,
    input  wire fcse_pkg::op_t   op,
    input  wire fcse_pkg::cfg_t  cfg,
    output fcse_pkg::result_t    res
);
    localparam int VB = fcse_pkg::VALUE_BITS;
    localparam int CB = fcse_pkg::CNT_BITS;

    logic [VB-1:0]        value_mem [fcse_pkg::MAX_NODES];
    logic [fcse_pkg::MAX_NODES-1:0] flag_reg, flag_next;
    logic        want_tx_reg, want_tx_next;
    logic        done_reg, done_next;
    logic        full_rx_reg, full_rx_next;
    logic        had_rx_reg, had_rx_next;
    logic        differs_reg, differs_next;
    logic [15:0] miss_reg, miss_next;
    logic [7:0]  txa_reg, txa_next;
    logic [3:0]  limit_reg, limit_next;
    logic [15:0] done_slot_reg, done_slot_next;
    logic [15:0] end_slot_reg, end_slot_next;
    logic [CB-1:0] merged_reg, merged_next;
    logic [CB-1:0] recv_reg, recv_next;
    logic [CB-1:0] nc;
    logic        rx_ok;
    logic        old_flag;
    logic        wr_val;
    logic [VB-1:0] wr_data;
    logic [1:0]  nxt;
    logic        rend;
    logic        cur_flag;
    logic        rmw_hit;
    logic [VB-1:0] rd_reg;
    fcse_pkg::result_t res_reg;

    fcse_pkg::item_t it;
    assign it = op.item;

    always_comb
    begin
        if (cfg.node_count == 7'd0)
            nc = CB'(1);
        else if (32'(cfg.node_count) > fcse_pkg::MAX_NODES)
            nc = CB'(fcse_pkg::MAX_NODES);
        else
            nc = CB'(cfg.node_count);
    end

    // merge and decide
    always_comb
    begin
        flag_next      = flag_reg;
        want_tx_next   = want_tx_reg;
        done_next      = done_reg;
        full_rx_next   = full_rx_reg;
        had_rx_next    = had_rx_reg;
        differs_next   = differs_reg;
        miss_next      = miss_reg;
        txa_next       = txa_reg;
        limit_next     = limit_reg;
        done_slot_next = done_slot_reg;
        end_slot_next  = end_slot_reg;
        merged_next    = merged_reg;
        recv_next      = recv_reg;
        wr_val         = 1'b0;
        wr_data        = it.rx_value;
        nxt            = fcse_pkg::NX_RX;
        rend           = 1'b0;
        rx_ok          = (it.slot_state == fcse_pkg::ST_RX) && it.txrx_ok;
        old_flag       = flag_reg[op.idx];
        if (it.command == fcse_pkg::CMD_START)
        begin
            flag_next      = '0;
            want_tx_next   = 1'b0;
            done_next      = 1'b0;
            full_rx_next   = 1'b0;
            had_rx_next    = 1'b0;
            differs_next   = 1'b0;
            miss_next      = '0;
            txa_next       = '0;
            done_slot_next = '0;
            end_slot_next  = cfg.max_slots;
            recv_next      = '0;
            merged_next    = op.in_range ? CB'(1) : '0;
            limit_next     = fcse_pkg::RESTART_MIN + {2'b00, it.random_word[1:0]};
            if (op.own_valid)
            begin
                flag_next[op.idx] = 1'b1;
                wr_val  = 1'b1;
                wr_data = it.own_value;
            end
        end
        else
        begin
            if (op.in_range && rx_ok)
            begin
                if (!done_reg)
                begin
                    wr_val = it.rx_flag;
                    if (it.rx_flag != old_flag)
                        differs_next = 1'b1;
                    if (it.rx_flag && !old_flag)
                    begin
                        flag_next[op.idx] = 1'b1;
                        merged_next = merged_reg + 1'b1;
                    end
                end
                else if (it.rx_flag)
                begin
                    // hold the count at its top; it is only compared with nc
                    if (recv_reg != '1)
                        recv_next = recv_reg + 1'b1;
                end
            end
            if (it.last_entry)
            begin
                if (rx_ok && !done_reg)
                begin
                    had_rx_next  = 1'b1;
                    want_tx_next = differs_next;
                    if (merged_next >= nc)
                    begin
                        done_slot_next = it.slot_number;
                        want_tx_next   = 1'b1;
                        done_next      = 1'b1;
                    end
                end
                else if (rx_ok && done_reg)
                begin
                    if (recv_next >= nc)
                        full_rx_next = 1'b1;
                end
                if (cfg.initiator && it.slot_state == fcse_pkg::ST_INIT)
                begin
                    nxt         = fcse_pkg::NX_TX;
                    had_rx_next = 1'b1;
                end
                else if (rx_ok)
                begin
                    miss_next = '0;
                    if (want_tx_next)
                    begin
                        nxt = fcse_pkg::NX_TX;
                        if (done_next && txa_reg != 8'hFF)
                            txa_next = txa_reg + 1'b1;
                    end
                end
                else if (it.slot_state == fcse_pkg::ST_RX && had_rx_next)
                begin
                    if (miss_reg != 16'hFFFF)
                        miss_next = miss_reg + 1'b1;
                    if (miss_next > {12'd0, limit_reg})
                    begin
                        nxt       = fcse_pkg::NX_TX;
                        miss_next = '0;
                        if (done_reg && txa_reg != 8'hFF)
                            txa_next = txa_reg + 1'b1;
                        limit_next = fcse_pkg::RESTART_MIN
                                     + {2'b00, it.random_word[1:0]};
                    end
                end
                else if (it.slot_state == fcse_pkg::ST_TX && !it.txrx_ok)
                begin
                    had_rx_next = 1'b1;
                    nxt         = fcse_pkg::NX_TX;
                end
                else if (it.slot_state == fcse_pkg::ST_TX && full_rx_reg
                         && txa_reg >= cfg.tx_complete_target)
                    nxt = fcse_pkg::NX_OFF;
                rend = ({1'b0, it.slot_number} + 17'd1 >= {1'b0, cfg.max_slots})
                       || nxt == fcse_pkg::NX_OFF;
                if (rend)
                    end_slot_next = it.slot_number;
                differs_next = 1'b0;
                recv_next    = '0;
            end
        end
        cur_flag = flag_next[op.idx];
    end

    // write value store and capture read data
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (wr_val)
                value_mem[op.idx] <= wr_data;
            rd_reg <= value_mem[op.idx];
        end
    end

    // hold result fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= '0;
            want_tx_reg   <= 1'b0;
            done_reg      <= 1'b0;
            full_rx_reg   <= 1'b0;
            had_rx_reg    <= 1'b0;
            differs_reg   <= 1'b0;
            miss_reg      <= '0;
            txa_reg       <= '0;
            limit_reg     <= fcse_pkg::RESTART_MIN;
            done_slot_reg <= '0;
            end_slot_reg  <= 16'd1000;
            merged_reg    <= '0;
            recv_reg      <= '0;
            rmw_hit       <= 1'b0;
            res_reg.stored_flag     <= 1'b0;
            res_reg.stored_value    <= '0;
            res_reg.decision_valid  <= 1'b0;
            res_reg.slot_action     <= fcse_pkg::NX_RX;
            res_reg.is_complete     <= 1'b0;
            res_reg.complete_at     <= '0;
            res_reg.round_end       <= 1'b0;
            res_reg.closing_slot    <= 16'd1000;
        end
        else if (go)
        begin
            flag_reg      <= flag_next;
            want_tx_reg   <= want_tx_next;
            done_reg      <= done_next;
            full_rx_reg   <= full_rx_next;
            had_rx_reg    <= had_rx_next;
            differs_reg   <= differs_next;
            miss_reg      <= miss_next;
            txa_reg       <= txa_next;
            limit_reg     <= limit_next;
            done_slot_reg <= done_slot_next;
            end_slot_reg  <= end_slot_next;
            merged_reg    <= merged_next;
            recv_reg      <= recv_next;
            rmw_hit       <= wr_val;
            res_reg.stored_flag     <= cur_flag;
            res_reg.stored_value    <= wr_data;
            res_reg.decision_valid  <= it.command != fcse_pkg::CMD_START && it.last_entry;
            res_reg.slot_action     <= nxt;
            res_reg.is_complete     <= done_next;
            res_reg.complete_at     <= done_slot_next;
            res_reg.round_end       <= rend;
            res_reg.closing_slot    <= end_slot_next;
        end
    end

    // value is the written data, the store entry, or zero when the flag is clear
    always_comb
    begin
        res = res_reg;
        if (!res_reg.stored_flag)
            res.stored_value = '0;
        else if (!rmw_hit)
            res.stored_value = rd_reg;
    end
endmodule
`default_nettype wire

@@ hdl/flood_collect_slot_engine_unit.sv @@
// Path: an accepted item is registered in the queue, then in the result register when the back end advances.
// Throughput: one item per cycle while results are popped; the store read-modify-write
// in the back end sets that figure. A held result stalls input after two more items.
// Reset: all control state clears; configuration returns to its reset values.
// The value store is not cleared; an entry whose flag is clear reads as zero.
`default_nettype none
`include "flood_collect_slot_engine_unit_defines.svh"
// ----------------------------------------------------------------------------
// flood_collect_slot_engine_unit
// Top level: config registers, front classifier, queue, back engine, output result slot.
// ----------------------------------------------------------------------------
module flood_collect_slot_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [15:0] own_value,
    input  wire logic [1:0]  slot_state,
    input  wire logic        txrx_ok,
    input  wire logic [15:0] slot_number,
    input  wire logic [15:0] random_word,
    input  wire logic        rx_flag,
    input  wire logic [15:0] rx_value,
    input  wire logic        last_entry,
    output logic             empty,
    input  wire logic        pop,
    output logic             stored_flag,
    output logic [15:0]      stored_value,
    output logic             decision_valid,
    output logic [1:0]       slot_action,
    output logic             is_complete,
    output logic [15:0]      complete_at,
    output logic             round_end,
    output logic [15:0]      closing_slot,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    fcse_pkg::cfg_t    cfg_reg;
    fcse_pkg::item_t   item;
    fcse_pkg::op_t     fop;
    fcse_pkg::op_t     qop;
    fcse_pkg::result_t res;
    logic take;
    logic q_full;
    logic q_empty;
    logic go;
    logic out_valid_reg;

    assign cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count         <= 7'd64;
            cfg_reg.own_index          <= 6'd0;
            cfg_reg.initiator          <= 1'b0;
            cfg_reg.max_slots          <= 16'd1000;
            cfg_reg.tx_complete_target <= 8'd9;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fcse_pkg::REG_NODE_COUNT: cfg_reg.node_count <= cfg_data[6:0];
                fcse_pkg::REG_OWN_INDEX:  cfg_reg.own_index <= cfg_data[5:0];
                fcse_pkg::REG_INITIATOR:  cfg_reg.initiator <= cfg_data[0];
                fcse_pkg::REG_MAX_SLOTS:  cfg_reg.max_slots <= cfg_data;
                fcse_pkg::REG_TX_TARGET:  cfg_reg.tx_complete_target <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign item = '{command, own_value, slot_state, txrx_ok, slot_number,
                    random_word, rx_flag, rx_value, last_entry};
    assign full = q_full;
    assign take = push && !q_full;

    fcse_front u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .take (take),
        .item (item),
        .cfg  (cfg_reg),
        .op   (fop)
    );

    fcse_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (take),
        .wdata(fop),
        .full (q_full),
        .rd   (go),
        .rdata(qop),
        .empty(q_empty)
    );

    // advance back end when the result slot is free or being drained
    assign go = !q_empty && (!out_valid_reg || pop);

    fcse_back u_back (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (go),
        .op   (qop),
        .cfg  (cfg_reg),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (go)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign empty          = !out_valid_reg;
    assign stored_flag    = res.stored_flag;
    assign stored_value   = res.stored_value;
    assign decision_valid = res.decision_valid;
    assign slot_action    = res.slot_action;
    assign is_complete    = res.is_complete;
    assign complete_at    = res.complete_at;
    assign round_end      = res.round_end;
    assign closing_slot   = res.closing_slot;

    `FCSE_ASSERT_IMPL(a_dec_only, clk, rst_n, !empty && !decision_valid,
        slot_action == fcse_pkg::NX_RX && !round_end, "next action without decision")
    `FCSE_ASSERT_NEXT(a_go_fills, clk, rst_n, go, !empty, "result lost after advance")
    `FCSE_ASSERT_IMPL(a_no_take_full, clk, rst_n, take, !q_full, "accept while queue full")
endmodule
`default_nettype wire
